// File: design/smf_pkg.sv
// Shared types and constants for the sliding median filter.
// No dependencies; compile first.
package smf_pkg;

  localparam int PIX_W = 8;

  typedef logic [PIX_W-1:0] pix_t;

endpackage

// File: design/smf_pix_if.sv
// Input word channel: one grey pixel plus end-of-frame flag.
// Depends on smf_pkg.
interface smf_pix_if
  import smf_pkg::*;
();
  logic valid;
  logic ready;
  pix_t pixel;
  logic end_of_frame;

  modport source (output valid, output pixel, output end_of_frame, input ready);
  modport sink   (input valid, input pixel, input end_of_frame, output ready);
endinterface

// File: design/smf_med_if.sv
// Result word channel: one median value plus frame-last flag.
// Depends on smf_pkg.
interface smf_med_if
  import smf_pkg::*;
();
  logic valid;
  logic ready;
  pix_t median_value;
  logic last;

  modport source (output valid, output median_value, output last, input ready);
  modport sink   (input valid, input median_value, input last, output ready);
endinterface

// File: design/smf_window.sv
// Pending-pixel store, fill count and end-of-frame flush sequencing.
// Builds one full window per cycle into the job register if free. Depends on smf_pkg.
module smf_window
  import smf_pkg::*;
#(
  parameter int WINDOW = 13
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  pix_t                     in_pixel,
  input  logic                     in_eof,
  output logic                     job_valid,
  input  logic                     job_ready,
  output pix_t [WINDOW-1:0]        job_win,
  output logic                     job_last
);

  localparam int CW    = $clog2(WINDOW);
  localparam int DEPTH = WINDOW - 1;

  pix_t              win_r [DEPTH];
  pix_t              win_nxt [DEPTH];
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              flush_r, flush_nxt;
  pix_t              pad_r, pad_nxt;
  logic              job_valid_r, job_valid_nxt;
  pix_t [WINDOW-1:0] job_win_r, job_win_nxt;
  logic              job_last_r, job_last_nxt;

  logic              job_ld;
  logic              acc;
  logic              full;
  logic              emit;
  logic              shift;
  pix_t              pad;
  pix_t [WINDOW-1:0] wvec;

  assign job_ld   = !job_valid_r || job_ready;
  assign in_ready = !flush_r && job_ld;
  assign acc      = in_valid && in_ready;
  assign full     = (cnt_r == CW'(DEPTH));
  assign pad      = flush_r ? pad_r : in_pixel;
  assign emit     = (flush_r && job_ld) || (acc && (in_eof || full));

  // window: pending entries first, then padding
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      wvec[i] = (CW'(i) < cnt_r) ? win_r[i] : pad;
    end
    wvec[WINDOW-1] = pad;
  end

  always_comb begin
    flush_nxt = flush_r;
    pad_nxt   = pad_r;
    cnt_nxt   = cnt_r;
    shift     = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      win_nxt[i] = win_r[i];
    end

    if (flush_r && job_ld) begin
      if (cnt_r == '0) begin
        flush_nxt = 1'b0;
      end else begin
        shift   = 1'b1;
        cnt_nxt = cnt_r - CW'(1);
      end
    end else if (acc) begin
      if (in_eof) begin
        if (cnt_r != '0) begin
          flush_nxt = 1'b1;
          pad_nxt   = in_pixel;
          shift     = 1'b1;
          cnt_nxt   = cnt_r - CW'(1);
        end
      end else if (full) begin
        shift = 1'b1;
      end else begin
        for (int i = 0; i < DEPTH; i++) begin
          if (CW'(i) == cnt_r) begin
            win_nxt[i] = in_pixel;
          end
        end
        cnt_nxt = cnt_r + CW'(1);
      end
    end

    if (shift) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        win_nxt[i] = win_r[i+1];
      end
      win_nxt[DEPTH-1] = in_pixel;
    end
  end

  always_comb begin
    job_valid_nxt = job_valid_r;
    job_win_nxt   = job_win_r;
    job_last_nxt  = job_last_r;
    if (job_ld) begin
      job_valid_nxt = emit;
      job_win_nxt   = wvec;
      job_last_nxt  = (cnt_r == '0) && (flush_r || in_eof);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      flush_r     <= 1'b0;
      job_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      flush_r     <= flush_nxt;
      job_valid_r <= job_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r      <= win_nxt;
    pad_r      <= pad_nxt;
    job_win_r  <= job_win_nxt;
    job_last_r <= job_last_nxt;
  end

  assign job_valid = job_valid_r;
  assign job_win   = job_win_r;
  assign job_last  = job_last_r;

endmodule

// File: design/smf_median.sv
// Rank-select median of one registered window into the result register.
// Depends on smf_pkg.
module smf_median
  import smf_pkg::*;
#(
  parameter int WINDOW = 13
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_ready,
  input  pix_t [WINDOW-1:0] job_win,
  input  logic              job_last,
  output logic              out_valid,
  input  logic              out_ready,
  output pix_t              out_median,
  output logic              out_last
);

  localparam int CW  = $clog2(WINDOW);
  localparam int MID = WINDOW / 2;

  logic [CW-1:0] rank [WINDOW];
  pix_t          med;
  logic          out_ld;
  logic          out_valid_r, out_valid_nxt;
  pix_t          out_median_r, out_median_nxt;
  logic          out_last_r, out_last_nxt;

  // rank of each sample, ties broken by slot order; exactly one hits MID
  always_comb begin
    for (int j = 0; j < WINDOW; j++) begin
      rank[j] = '0;
      for (int i = 0; i < WINDOW; i++) begin
        if (i != j) begin
          if ((job_win[i] < job_win[j]) || ((job_win[i] == job_win[j]) && (i < j))) begin
            rank[j] = rank[j] + CW'(1);
          end
        end
      end
    end
  end

  always_comb begin
    med = '0;
    for (int j = 0; j < WINDOW; j++) begin
      if (rank[j] == CW'(MID)) begin
        med = med | job_win[j];
      end
    end
  end

  assign out_ld    = !out_valid_r || out_ready;
  assign job_ready = out_ld;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_median_nxt = out_median_r;
    out_last_nxt   = out_last_r;
    if (out_ld) begin
      out_valid_nxt  = job_valid;
      out_median_nxt = med;
      out_last_nxt   = job_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_median_r <= out_median_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_median = out_median_r;
  assign out_last   = out_last_r;

endmodule

// File: design/sliding_median_filter.sv
// Forward running median over a raster pixel stream: each result is the median of a
// pixel and the WINDOW-1 pixels after it. The first WINDOW-1 words of a frame give no
// result; after that every input word gives one result via the job and result
// registers. The word marked end_of_frame flushes the positions still pending, padding
// with the final pixel: input ready then stays low while they drain (up to WINDOW-1),
// as the single median unit gives one result per clock unless out_ch stalls. Otherwise
// one word is taken every clock unless out_ch stalls. No clearing pass after reset.
module sliding_median_filter
  import smf_pkg::*;
#(
  parameter int WINDOW = 13
) (
  input  logic        clk,
  input  logic        rst_n,
  smf_pix_if.sink     in_ch,
  smf_med_if.source   out_ch
);

  logic              job_valid;
  logic              job_ready;
  pix_t [WINDOW-1:0] job_win;
  logic              job_last;

  smf_window #(
    .WINDOW(WINDOW)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_pixel  (in_ch.pixel),
    .in_eof    (in_ch.end_of_frame),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job_win   (job_win),
    .job_last  (job_last)
  );

  smf_median #(
    .WINDOW(WINDOW)
  ) u_median (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (job_valid),
    .job_ready  (job_ready),
    .job_win    (job_win),
    .job_last   (job_last),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_median (out_ch.median_value),
    .out_last   (out_ch.last)
  );

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for sliding_median_filter: directed and random frames,
// predicted median words compared in order. Depends on smf_pkg, smf_pix_if and
// smf_med_if.
module testbench;
  import smf_pkg::*;

  localparam int WINDOW         = 13;
  localparam int DEPTH          = WINDOW - 1;
  localparam int MID_RANK       = WINDOW / 2;
  localparam int SRC_SIDE       = 0;
  localparam int SNK_SIDE       = 1;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RANDOM_PIXELS  = 117;

  typedef struct packed {
    pix_t median_value;
    logic last;
  } median_word_t;

  typedef pix_t span_t [2*WINDOW];

  typedef enum int {PIX_UNIFORM, PIX_CLUSTER, PIX_FLAT, PIX_RAILS} pix_style_t;

  logic clk;
  logic rst_n;

  smf_pix_if pix_ch ();
  smf_med_if med_ch ();

  sliding_median_filter #(
    .WINDOW(WINDOW)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (pix_ch),
    .out_ch(med_ch)
  );

  median_word_t expected_medians[$];
  pix_t         pending_pix [DEPTH];
  int           pending_count;
  int           calm_left [2];
  int           mismatch_count;
  int           pixels_seen;
  int           frames_seen;
  int           medians_seen;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("timeout after %0d cycles, %0d medians outstanding", TIMEOUT_CYCLES,
             expected_medians.size());
    $display("testbench NOT OK");
    $finish;
  end

  function automatic pix_t window_median(span_t span, int start);
    pix_t sorted [WINDOW];
    pix_t v;
    int   j;
    for (int i = 0; i < WINDOW; i++) sorted[i] = span[start + i];
    for (int i = 1; i < WINDOW; i++) begin
      v = sorted[i];
      j = i - 1;
      while (j >= 0 && sorted[j] > v) begin
        sorted[j + 1] = sorted[j];
        j--;
      end
      sorted[j + 1] = v;
    end
    return sorted[MID_RANK];
  endfunction

  function automatic void expect_word(pix_t med, logic last_flag);
    median_word_t w;
    w.median_value = med;
    w.last         = last_flag;
    expected_medians.insert(expected_medians.size(), w);
  endfunction

  // Window slots past the stored pixels take the incoming pixel.
  function automatic void predict_word(pix_t px, logic eof);
    span_t span;
    int    n;
    n = pending_count;
    for (int i = 0; i < 2*WINDOW; i++) span[i] = (i < n) ? pending_pix[i] : px;
    if (eof) begin
      for (int i = 0; i <= n; i++)
        expect_word(window_median(span, i), i == n);
      pending_count = 0;
    end else if (n == DEPTH) begin
      expect_word(window_median(span, 0), 1'b0);
      for (int i = 0; i < DEPTH; i++) pending_pix[i] = span[i + 1];
    end else begin
      pending_pix[n] = px;
      pending_count  = n + 1;
    end
  endfunction

  function automatic int draw_wait(int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm_left[side] = $urandom_range(8, 40);
    return ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic pix_t random_pixel(pix_style_t style, pix_t base);
    case (style)
      PIX_CLUSTER: return base + pix_t'($urandom_range(0, 7)) - pix_t'(4);
      PIX_FLAT:    return ($urandom_range(0, 7) == 0) ? pix_t'($urandom) : base;
      PIX_RAILS:   return $urandom_range(0, 1) ? pix_t'('1) : pix_t'(0);
      default:     return pix_t'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Input and result words are both observed here; prediction runs first.
  always @(posedge clk) begin
    median_word_t want;
    if (rst_n === 1'b1) begin
      if (pix_ch.valid && pix_ch.ready) begin
        predict_word(pix_ch.pixel, pix_ch.end_of_frame);
        pixels_seen++;
        if (pix_ch.end_of_frame) frames_seen++;
      end
      if (med_ch.valid && med_ch.ready) begin
        medians_seen++;
        if (expected_medians.size() == 0) begin
          report_mismatch($sformatf("unexpected word median %0d last %0b",
                                    med_ch.median_value, med_ch.last));
        end else begin
          want = expected_medians.pop_front();
          if (med_ch.median_value !== want.median_value)
            report_mismatch($sformatf("median word %0d: median_value %0d, want %0d",
                                      medians_seen, med_ch.median_value,
                                      want.median_value));
          if (med_ch.last !== want.last)
            report_mismatch($sformatf("median word %0d: last %0b, want %0b",
                                      medians_seen, med_ch.last, want.last));
        end
      end
    end
  end

  // Result side: random stall before each word.
  initial begin
    int stall;
    med_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_wait(SNK_SIDE);
      if (stall > 0) begin
        med_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      med_ch.ready <= 1'b1;
      @(posedge clk);
      while (!med_ch.valid) @(posedge clk);
    end
  end

  task automatic send_pixel(input pix_t px, input logic eof);
    int gap;
    gap = draw_wait(SRC_SIDE);
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid        <= 1'b1;
    pix_ch.pixel        <= px;
    pix_ch.end_of_frame <= eof;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    pix_ch.valid <= 1'b0;
    while (expected_medians.size() != 0) @(posedge clk);
  endtask

  // One-pixel frames, a short frame, then a frame that fills, slides once and
  // flushes the deepest backlog.
  task automatic test_directed_frames();
    pix_t full_frame [WINDOW + 1];
    send_pixel(pix_t'('1), 1'b1);
    send_pixel(pix_t'(0), 1'b1);
    send_pixel(pix_t'(0), 1'b0);
    send_pixel(pix_t'('1), 1'b0);
    send_pixel(pix_t'(8'h80), 1'b1);
    for (int i = 0; i <= WINDOW; i++)
      full_frame[i] = (i % 3 == 0) ? pix_t'('1) : (i % 3 == 1) ? pix_t'(0) : pix_t'(8'h55 + i);
    for (int i = 0; i <= WINDOW; i++) send_pixel(full_frame[i], i == WINDOW);
  endtask

  // Sender holds off mid-frame until every predicted median has been seen.
  task automatic test_drain_midframe();
    int frame_len;
    frame_len = 24;
    for (int i = 0; i < frame_len; i++) begin
      if (i == 5 || i == 16) wait_drained();
      send_pixel(pix_t'($urandom), i == frame_len - 1);
    end
  endtask

  task automatic test_random_frames();
    int         frame_len;
    int         sent;
    pix_style_t style;
    pix_t       base;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      case ($urandom_range(0, 9))
        0:       frame_len = $urandom_range(1, DEPTH);
        1:       frame_len = $urandom_range(60, 90);
        default: frame_len = $urandom_range(WINDOW, 40);
      endcase
      if (frame_len > RANDOM_PIXELS - sent) frame_len = RANDOM_PIXELS - sent;
      style = pix_style_t'($urandom_range(0, 3));
      base  = pix_t'($urandom);
      for (int i = 0; i < frame_len; i++)
        send_pixel(random_pixel(style, base), i == frame_len - 1);
      sent += frame_len;
    end
  endtask

  initial begin
    rst_n               <= 1'b0;
    pix_ch.valid        <= 1'b0;
    pix_ch.pixel        <= '0;
    pix_ch.end_of_frame <= 1'b0;
    pending_count  = 0;
    mismatch_count = 0;
    pixels_seen    = 0;
    frames_seen    = 0;
    medians_seen   = 0;
    calm_left[SRC_SIDE] = 0;
    calm_left[SNK_SIDE] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_frames();
    test_drain_midframe();
    test_random_frames();

    pix_ch.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d pixel words in %0d frames", pixels_seen, frames_seen);
    $display("(one-pixel, short, full flush, mid-frame hold); checked %0d median words, %0d mismatches",
             medians_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
design/smf_pkg.sv
design/smf_pix_if.sv
design/smf_med_if.sv
design/smf_window.sv
design/smf_median.sv
design/sliding_median_filter.sv
dv/testbench.sv
